@@ hdl/hscd_pkg.sv @@
// Shared types and constants for the header-sync checksum deframer.
// Used by hscd_acc, hscd_pbuf and header_sync_checksum_deframer.
package hscd_pkg;

  localparam int HEADER_BYTES  = 4;
  localparam int PACKET_BYTES  = 18;
  localparam int PAYLOAD_BYTES = 12;

  localparam int HDR_W   = 8 * HEADER_BYTES;
  localparam int IDX_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int PKT_W   = $clog2(PACKET_BYTES);
  localparam int POS_W   = (PKT_W > IDX_W) ? PKT_W : IDX_W;
  localparam int HCNT_W  = $clog2(HEADER_BYTES + 1);
  localparam int SUM_W   = 16;

  // Configuration register indexes.
  typedef enum logic {
    REG_HEADER_WORD     = 1'b0,
    REG_CSUM_HIGH_FIRST = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HSUM,
    ST_EMIT
  } state_e;

  // Control of the shared 16-bit accumulator.
  typedef struct packed {
    logic       clr;
    logic       add;
    logic [7:0] operand;
  } acc_ctrl_t;

  // Control of the payload buffers.
  typedef struct packed {
    logic             stage_we;
    logic [IDX_W-1:0] stage_idx;
    logic [7:0]       stage_data;
    logic [IDX_W-1:0] rd_idx;
    logic             use_new;
    logic             commit;
  } pbuf_ctrl_t;

endpackage

@@ hdl/hscd_acc.sv @@
// Shared wrapping 16-bit adder with its accumulator register.
// Depends on hscd_pkg for the control struct.
module hscd_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hscd_pkg::acc_ctrl_t ctrl_i,
  output logic [15:0]         sum_o
);
  import hscd_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.add) begin
      sum_d = sum_q + {{(SUM_W-8){1'b0}}, ctrl_i.operand};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ hdl/hscd_pbuf.sv @@
// Staged and last-good payload registers with the emit-side read port.
// Depends on hscd_pkg for sizes and the control struct.
module hscd_pbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hscd_pkg::pbuf_ctrl_t ctrl_i,
  output logic [7:0]           rd_data_o
);
  import hscd_pkg::*;

  logic [7:0] staged_q [PAYLOAD_BYTES];
  logic [7:0] good_q   [PAYLOAD_BYTES];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.stage_we) begin
      staged_q[ctrl_i.stage_idx] <= ctrl_i.stage_data;
    end
  end

  // A good packet is copied into the last-good store one entry per transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        good_q[i] <= '0;
      end
    end else if (ctrl_i.commit) begin
      good_q[ctrl_i.rd_idx] <= staged_q[ctrl_i.rd_idx];
    end
  end

  assign rd_data_o = ctrl_i.use_new ? staged_q[ctrl_i.rd_idx] : good_q[ctrl_i.rd_idx];

endmodule

@@ hdl/header_sync_checksum_deframer.sv @@
// Header-synchronized packet deframer with a 16-bit additive checksum.
// Byte input channel (in_valid_i/in_ready_o, byte_in_i) and payload output channel
// (out_valid_o/out_ready_i and four fields). Configuration is a plain write port:
// index 0 is the expected header word, index 1 selects checksum byte order.
// While hunting, every byte is compared with the header using the three bytes
// before it. On a match the block stops taking bytes while the shared adder
// sums the header bytes; other bytes are taken without a stall.
// Body bytes go through the same adder into the running sum and are staged.
// On the last checksum byte, the block emits PAYLOAD_BYTES (12) results, one per
// cycle at best, from the new payload if the checksum matched, otherwise from the
// last good one. No byte is taken while the run is emitted; if the receiver
// stalls, the current result holds until its transfer. The input is free again
// in the cycle after the run's final transfer.
// Reset clears the header window, the packet state, the running sum and the
// last-good payload; header word resets to zero and high-first order to one.
module header_sync_checksum_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  byte_index_o,
  output logic        packet_ok_o,
  output logic        last_of_run_o
);
  import hscd_pkg::*;

  state_e state_q, state_d;

  logic [31:0]       header_word_q;
  logic              csum_high_first_q;
  logic [23:0]       window_q, window_d;
  logic              in_packet_q, in_packet_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        first_q, first_d;
  logic              ok_q, ok_d;
  logic [IDX_W-1:0]  emit_idx_q, emit_idx_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;

  logic [31:0]      recent;
  logic [POS_W-1:0] stage_off;
  logic [15:0]      chk;
  logic [15:0]      run_sum;
  logic [7:0]       rd_data;
  logic             in_xfer, out_xfer, emit_last;
  acc_ctrl_t        acc_ctrl;
  pbuf_ctrl_t       pbuf_ctrl;

  hscd_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .sum_o  (run_sum)
  );

  hscd_pbuf u_pbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pbuf_ctrl),
    .rd_data_o (rd_data)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_word_q     <= '0;
      csum_high_first_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER_WORD:     header_word_q     <= cfg_data_i;
        REG_CSUM_HIGH_FIRST: csum_high_first_q <= cfg_data_i[0];
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_xfer   = out_valid_o && out_ready_i;
  assign emit_last  = (emit_idx_q == IDX_W'(PAYLOAD_BYTES - 1));

  assign recent    = {window_q, byte_in_i};
  assign stage_off = pos_q - POS_W'(HEADER_BYTES);
  assign chk       = csum_high_first_q ? {first_q, byte_in_i} : {byte_in_i, first_q};

  always_comb begin
    state_d    = state_q;
    window_d   = window_q;
    in_packet_d = in_packet_q;
    pos_d      = pos_q;
    first_d    = first_q;
    ok_d       = ok_q;
    emit_idx_d = emit_idx_q;
    hdr_d      = hdr_q;
    hcnt_d     = hcnt_q;

    acc_ctrl           = '0;
    pbuf_ctrl          = '0;
    pbuf_ctrl.stage_idx  = stage_off[IDX_W-1:0];
    pbuf_ctrl.stage_data = byte_in_i;
    pbuf_ctrl.rd_idx     = emit_idx_q;
    pbuf_ctrl.use_new    = ok_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          window_d = recent[23:0];
          if (!in_packet_q) begin
            if (recent[HDR_W-1:0] == header_word_q[31 -: HDR_W]) begin
              acc_ctrl.clr = 1'b1;
              hdr_d        = recent[HDR_W-1:0];
              hcnt_d       = '0;
              in_packet_d  = 1'b1;
              pos_d        = POS_W'(HEADER_BYTES);
              state_d      = ST_HSUM;
            end
          end else if (pos_q < POS_W'(PACKET_BYTES - 2)) begin
            acc_ctrl.add     = 1'b1;
            acc_ctrl.operand = byte_in_i;
            pbuf_ctrl.stage_we = (pos_q >= POS_W'(HEADER_BYTES)) &&
                                 (stage_off < POS_W'(PAYLOAD_BYTES));
            pos_d = pos_q + 1'b1;
          end else if (pos_q == POS_W'(PACKET_BYTES - 2)) begin
            first_d = byte_in_i;
            pos_d   = pos_q + 1'b1;
          end else begin
            ok_d        = (chk == run_sum);
            emit_idx_d  = '0;
            in_packet_d = 1'b0;
            pos_d       = '0;
            state_d     = ST_EMIT;
          end
        end
      end
      ST_HSUM: begin
        // The header bytes go through the shared adder one per cycle.
        acc_ctrl.add     = 1'b1;
        acc_ctrl.operand = hdr_q[7:0];
        hdr_d            = hdr_q >> 8;
        hcnt_d           = hcnt_q + 1'b1;
        if (hcnt_q == HCNT_W'(HEADER_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        pbuf_ctrl.commit = out_xfer && ok_q;
        if (out_xfer) begin
          emit_idx_d = emit_idx_q + 1'b1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= '0;
      in_packet_q <= 1'b0;
      pos_q       <= '0;
      first_q     <= '0;
      ok_q        <= 1'b0;
      emit_idx_q  <= '0;
      hcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      in_packet_q <= in_packet_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      ok_q        <= ok_d;
      emit_idx_q  <= emit_idx_d;
      hcnt_q      <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  assign payload_byte_o = rd_data;
  assign byte_index_o   = 4'(emit_idx_q);
  assign packet_ok_o    = ok_q;
  assign last_of_run_o  = emit_last;

  a_no_input_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a payload run is pending");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (byte_index_o == 4'(PAYLOAD_BYTES - 1)))
    else $error("last flag on a wrong payload position");

  a_ready_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_run_o) |=> (in_ready_o && !in_packet_q))
    else $error("block not hunting after the payload run");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(PACKET_BYTES))
    else $error("packet position out of range");

endmodule
